@@ hdl/psu_pkg.sv @@
// Shared types, constants and helpers of the packed sample unpacker.
// No dependencies; most other files of the block import this package.
`default_nettype none

package psu_pkg;

	// Upper bound on color samples per pixel.
	localparam int MAX_COMPONENTS = 32;

	// Field widths of the configuration registers.
	localparam int CODE_W   = 3;
	localparam int COMPS_W  = 6;
	localparam int PIX_W    = 16;
	localparam int STRIDE_W = 24;
	localparam int ROWS_W   = 16;
	localparam int IDX_W    = 3;
	localparam int WDATA_W  = 24;

	// Derived widths.
	localparam int COMP_IDX_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int MOD_W       = COMPS_W + 1;
	localparam int TOTAL_W     = PIX_W + COMPS_W;
	localparam int DATA_W      = TOTAL_W + 1;
	localparam int FIRST_W     = STRIDE_W + 3;
	localparam int FIRST_CNT_W = $clog2(FIRST_W);
	localparam int NSAMP_W     = 4;

	// Queue between the front and back ends.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Register indexes of the configuration port.
	typedef enum logic [IDX_W-1:0] {
		REG_DEPTH_CODE = 3'd0,
		REG_COMPONENTS = 3'd1,
		REG_ADD_ALPHA  = 3'd2,
		REG_ROW_PIXELS = 3'd3,
		REG_ROW_STRIDE = 3'd4,
		REG_ROW_COUNT  = 3'd5
	} reg_idx_t;

	// Depth codes.
	localparam logic [CODE_W-1:0] CODE_1  = 3'd0;
	localparam logic [CODE_W-1:0] CODE_2  = 3'd1;
	localparam logic [CODE_W-1:0] CODE_4  = 3'd2;
	localparam logic [CODE_W-1:0] CODE_8  = 3'd3;
	localparam logic [CODE_W-1:0] CODE_16 = 3'd4;

	// Effective image geometry, held by the configuration unit.
	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [COMPS_W-1:0]  comps;
		logic                add_alpha;
		logic [7:0]          alpha_val;
		logic [TOTAL_W-1:0]  total;
		logic [STRIDE_W-1:0] stride;
		logic [ROWS_W-1:0]   rows;
	} geom_t;

	// Component counter reload after a configuration change.
	typedef struct packed {
		logic                  load;
		logic [COMP_IDX_W-1:0] comp;
	} comp_sync_t;

	// One classified source byte that yields at least one sample.
	typedef struct packed {
		logic [7:0]         data;
		logic [NSAMP_W-1:0] n;
		logic               row_fin;
		logic               last_row;
		logic               row_start;
	} entry_t;

	// Index of the first sample held by a byte of the row.
	function automatic logic [FIRST_W-1:0] first_sample(input logic [STRIDE_W-1:0] bir,
			input logic [CODE_W-1:0] code);
		logic [FIRST_W-1:0] wide;
		wide = FIRST_W'(bir);
		if (code == CODE_16) begin
			return wide >> 1;
		end else begin
			return wide << (CODE_8 - code);
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/psu_ifs.sv @@
// Valid/ready channel interfaces of the packed sample unpacker.
// Depends on nothing; the top level and the end modules use them.
`default_nettype none

interface psu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

interface psu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       is_alpha;
	logic       row_end;
	logic       image_end;
	logic       last;

	modport source (output valid, output sample, output is_alpha, output row_end,
		output image_end, output last, input ready);
	modport sink (input valid, input sample, input is_alpha, input row_end,
		input image_end, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/psu_cfg.sv @@
// Configuration registers and the geometry recompute sequencer.
// Depends on psu_pkg. After each write it recomputes the row size and the component phase.
`default_nettype none

module psu_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [psu_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [psu_pkg::WDATA_W-1:0]   cfg_wdata,
	input  wire logic [psu_pkg::STRIDE_W-1:0]  bir,
	output psu_pkg::geom_t                     geom,
	output logic                               busy,
	output psu_pkg::comp_sync_t                sync
);
	import psu_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_TOTAL, ST_SIZE, ST_STRIDE, ST_MOD} state_t;

	state_t                 state_q;
	logic [CODE_W-1:0]      depth_code_q;
	logic [COMPS_W-1:0]     components_q;
	logic                   add_alpha_q;
	logic [PIX_W-1:0]       row_pixels_q;
	logic [STRIDE_W-1:0]    row_stride_q;
	logic [ROWS_W-1:0]      row_count_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [DATA_W-1:0]      data_q;
	logic [STRIDE_W-1:0]    stride_eff_q;
	logic [COMP_IDX_W-1:0]  rem_q;
	logic [FIRST_CNT_W-1:0] bitcnt_q;
	comp_sync_t             sync_q;

	logic [CODE_W-1:0]  code_eff;
	logic [COMPS_W-1:0] comps_eff;
	logic [ROWS_W-1:0]  rows_eff;
	logic [7:0]         alpha_val;
	logic [FIRST_W-1:0] dividend;
	logic [MOD_W-1:0]   rem_shift;
	logic [MOD_W-1:0]   rem_next;
	logic [DATA_W-1:0]  data_round;
	logic [STRIDE_W-1:0] stride_max;

	// Out-of-range register values fall back to their nearest meaning.
	always_comb begin
		code_eff = (depth_code_q > CODE_16) ? CODE_16 : depth_code_q;
		if (components_q == '0) begin
			comps_eff = COMPS_W'(1);
		end else if (components_q > COMPS_W'(MAX_COMPONENTS)) begin
			comps_eff = COMPS_W'(MAX_COMPONENTS);
		end else begin
			comps_eff = components_q;
		end
		rows_eff = (row_count_q == '0) ? ROWS_W'(1) : row_count_q;
		case (code_eff)
			CODE_1:  alpha_val = 8'd1;
			CODE_2:  alpha_val = 8'd3;
			CODE_4:  alpha_val = 8'd15;
			default: alpha_val = 8'd255;
		endcase
	end

	// Geometry seen by the front and back ends.
	always_comb begin
		geom.code      = code_eff;
		geom.comps     = comps_eff;
		geom.add_alpha = add_alpha_q;
		geom.alpha_val = alpha_val;
		geom.total     = total_q;
		geom.stride    = stride_eff_q;
		geom.rows      = rows_eff;
	end

	// Datapath of the sequencer steps.
	always_comb begin
		dividend  = first_sample(bir, code_eff);
		rem_shift = MOD_W'({rem_q, dividend[bitcnt_q]});
		if (rem_shift >= MOD_W'(comps_eff)) begin
			rem_next = rem_shift - MOD_W'(comps_eff);
		end else begin
			rem_next = rem_shift;
		end
		// Bytes holding one row of packed samples, rounded up.
		data_round = ({1'b0, total_q} + DATA_W'(3'd7 >> code_eff)) >> (CODE_8 - code_eff);
		stride_max = (row_stride_q > STRIDE_W'(data_q)) ? row_stride_q : STRIDE_W'(data_q);
	end

	// Register file written by the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_code_q <= CODE_8;
			components_q <= COMPS_W'(1);
			add_alpha_q  <= 1'b0;
			row_pixels_q <= PIX_W'(1);
			row_stride_q <= STRIDE_W'(1);
			row_count_q  <= ROWS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEPTH_CODE: depth_code_q <= cfg_wdata[CODE_W-1:0];
				REG_COMPONENTS: components_q <= cfg_wdata[COMPS_W-1:0];
				REG_ADD_ALPHA:  add_alpha_q  <= cfg_wdata[0];
				REG_ROW_PIXELS: row_pixels_q <= cfg_wdata[PIX_W-1:0];
				REG_ROW_STRIDE: row_stride_q <= cfg_wdata[STRIDE_W-1:0];
				REG_ROW_COUNT:  row_count_q  <= cfg_wdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Recompute sequencer: row size, stride, then the component phase bit by bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= TOTAL_W'(1);
			data_q       <= DATA_W'(1);
			stride_eff_q <= STRIDE_W'(1);
			rem_q        <= '0;
			bitcnt_q     <= '0;
			sync_q       <= '0;
		end else begin
			sync_q.load <= !cfg_we && (state_q == ST_MOD) && (bitcnt_q == '0);
			if (cfg_we) begin
				state_q <= ST_TOTAL;
			end else begin
				case (state_q)
					ST_TOTAL: begin
						total_q <= TOTAL_W'(row_pixels_q * comps_eff);
						state_q <= ST_SIZE;
					end
					ST_SIZE: begin
						if (code_eff == CODE_16) begin
							data_q <= {total_q, 1'b0};
						end else begin
							data_q <= data_round;
						end
						state_q <= ST_STRIDE;
					end
					ST_STRIDE: begin
						stride_eff_q <= (stride_max == '0) ? STRIDE_W'(1) : stride_max;
						rem_q        <= '0;
						bitcnt_q     <= FIRST_CNT_W'(FIRST_W - 1);
						state_q      <= ST_MOD;
					end
					ST_MOD: begin
						rem_q <= COMP_IDX_W'(rem_next);
						if (bitcnt_q == '0) begin
							sync_q.comp <= COMP_IDX_W'(rem_next);
							state_q     <= ST_IDLE;
						end else begin
							bitcnt_q <= bitcnt_q - FIRST_CNT_W'(1);
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign sync = sync_q;

endmodule

`default_nettype wire

@@ hdl/psu_front.sv @@
// Front end: accepts source bytes, tracks the row position and classifies each byte.
// Depends on psu_pkg and psu_ifs. Feeds the queue with bytes that yield samples.
`default_nettype none

module psu_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	psu_in_if.sink                             in_ch,
	input  wire psu_pkg::geom_t                geom,
	input  wire logic                          busy,
	input  wire logic                          q_full,
	output logic                               push,
	output psu_pkg::entry_t                    push_entry,
	output logic [psu_pkg::STRIDE_W-1:0]       bir
);
	import psu_pkg::*;

	logic [STRIDE_W-1:0] bir_q;
	logic [ROWS_W-1:0]   row_idx_q;

	logic               accept;
	logic [FIRST_W-1:0] first;
	logic [FIRST_W-1:0] total_x;
	logic [FIRST_W-1:0] remaining;
	logic [NSAMP_W-1:0] cnt;
	logic [NSAMP_W-1:0] n;
	logic               in_range;
	logic               row_fin;
	logic               last_row;
	logic               wrap;

	assign in_ch.ready = !busy && !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Samples of the row that this byte holds.
	always_comb begin
		first     = first_sample(bir_q, geom.code);
		total_x   = FIRST_W'(geom.total);
		in_range  = first < total_x;
		remaining = total_x - first;
		if (geom.code == CODE_16) begin
			cnt = bir_q[0] ? '0 : NSAMP_W'(1);
		end else begin
			cnt = NSAMP_W'(4'd8 >> geom.code);
		end
		if (!in_range) begin
			n = '0;
		end else if (remaining < FIRST_W'(cnt)) begin
			n = remaining[NSAMP_W-1:0];
		end else begin
			n = cnt;
		end
		row_fin  = in_range && (remaining <= FIRST_W'(cnt));
		last_row = ({1'b0, row_idx_q} + (ROWS_W + 1)'(1)) >= {1'b0, geom.rows};
		wrap     = ({1'b0, bir_q} + (STRIDE_W + 1)'(1)) >= {1'b0, geom.stride};
	end

	// Queue entry for a byte with at least one sample.
	always_comb begin
		push                 = accept && (n != '0);
		push_entry.data      = in_ch.source_byte;
		push_entry.n         = n;
		push_entry.row_fin   = row_fin;
		push_entry.last_row  = last_row;
		push_entry.row_start = (bir_q == '0);
	end

	// Row position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q     <= '0;
			row_idx_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				bir_q     <= '0;
				row_idx_q <= last_row ? '0 : row_idx_q + ROWS_W'(1);
			end else begin
				bir_q <= bir_q + STRIDE_W'(1);
			end
		end
	end

	assign bir = bir_q;

endmodule

`default_nettype wire

@@ hdl/psu_queue.sv @@
// Short request queue between the front and back ends.
// Depends on psu_pkg. Head entry is visible while the queue is not empty.
`default_nettype none

module psu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire psu_pkg::entry_t push_entry,
	input  wire logic            pop,
	output psu_pkg::entry_t      head,
	output logic                 head_valid,
	output logic                 full
);
	import psu_pkg::*;

	entry_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));

endmodule

`default_nettype wire

@@ hdl/psu_back.sv @@
// Back end: splits queued bytes into samples, inserts alpha and drives the output register.
// Depends on psu_pkg and psu_ifs. Emits one result per cycle unless empty or stalled.
`default_nettype none

module psu_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire psu_pkg::geom_t      geom,
	input  wire psu_pkg::comp_sync_t sync,
	input  wire psu_pkg::entry_t     head,
	input  wire logic                head_valid,
	output logic                     pop,
	psu_out_if.source                out_ch
);
	import psu_pkg::*;

	logic [2:0]            j_q;
	logic                  alpha_q;
	logic [COMP_IDX_W-1:0] comp_q;
	logic                  valid_q;
	logic [7:0]            sample_q;
	logic                  is_alpha_q;
	logic                  row_end_q;
	logic                  image_end_q;
	logic                  last_q;

	logic                  take;
	logic [7:0]            smp;
	logic [COMP_IDX_W-1:0] comp_cur;
	logic                  pix_end;
	logic                  last_samp;
	logic                  rend;
	logic                  split;
	logic [7:0]            res_sample;
	logic                  res_alpha;
	logic                  res_rend;
	logic                  res_iend;
	logic                  res_last;

	// Sample field of the current position, MSB first.
	always_comb begin
		case (geom.code)
			CODE_1:  smp = 8'(head.data[3'd7 - j_q]);
			CODE_2:  smp = 8'(head.data[3'd7 - {j_q[1:0], 1'b0} -: 2]);
			CODE_4:  smp = j_q[0] ? {4'b0, head.data[3:0]} : {4'b0, head.data[7:4]};
			default: smp = head.data;
		endcase
	end

	// Result selection.
	always_comb begin
		comp_cur  = (head.row_start && (j_q == '0) && !alpha_q) ? '0 : comp_q;
		pix_end   = (MOD_W'(comp_cur) + MOD_W'(1)) == MOD_W'(geom.comps);
		last_samp = ({1'b0, j_q} + NSAMP_W'(1)) == head.n;
		rend      = head.row_fin && last_samp;
		split     = !alpha_q && geom.add_alpha && pix_end;
		if (alpha_q) begin
			res_sample = geom.alpha_val;
			res_alpha  = 1'b1;
			res_rend   = rend;
			res_iend   = rend && head.last_row;
			res_last   = last_samp;
		end else if (split) begin
			res_sample = smp;
			res_alpha  = 1'b0;
			res_rend   = 1'b0;
			res_iend   = 1'b0;
			res_last   = 1'b0;
		end else begin
			res_sample = smp;
			res_alpha  = 1'b0;
			res_rend   = rend;
			res_iend   = rend && head.last_row;
			res_last   = last_samp;
		end
	end

	assign take = head_valid && (!valid_q || out_ch.ready);
	assign pop  = take && !split && last_samp;

	// Position within the head entry and the pixel component phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			alpha_q <= 1'b0;
			comp_q  <= '0;
		end else if (sync.load) begin
			comp_q <= sync.comp;
		end else if (take) begin
			if (!alpha_q) begin
				comp_q <= pix_end ? '0 : comp_cur + COMP_IDX_W'(1);
			end
			if (split) begin
				alpha_q <= 1'b1;
			end else begin
				alpha_q <= 1'b0;
				j_q     <= last_samp ? '0 : j_q + 3'd1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q    <= res_sample;
			is_alpha_q  <= res_alpha;
			row_end_q   <= res_rend;
			image_end_q <= res_iend;
			last_q      <= res_last;
		end
	end

	assign out_ch.valid     = valid_q;
	assign out_ch.sample    = sample_q;
	assign out_ch.is_alpha  = is_alpha_q;
	assign out_ch.row_end   = row_end_q;
	assign out_ch.image_end = image_end_q;
	assign out_ch.last      = last_q;

endmodule

`default_nettype wire

@@ hdl/packed_sample_unpacker.sv @@
// Packed sample unpacker: an accepted byte passes through the queue and the output register,
// then results follow at one per cycle while the output is not stalled, up to 16 per byte at
// one bit with alpha. The back end's single output port sets that rate; a four-entry queue
// decouples the ends. Each configuration write starts a recompute; no byte is taken during it.
// Reset loads the register defaults and clears the row position, queue and output valid.
`default_nettype none

module packed_sample_unpacker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [psu_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [psu_pkg::WDATA_W-1:0] cfg_wdata,
	psu_in_if.sink                           in_ch,
	psu_out_if.source                        out_ch
);
	import psu_pkg::*;

	geom_t               geom;
	comp_sync_t          sync;
	entry_t              push_entry;
	entry_t              head;
	logic                busy;
	logic                push;
	logic                pop;
	logic                head_valid;
	logic                q_full;
	logic [STRIDE_W-1:0] bir;

	// Configuration and geometry.
	psu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.bir       (bir),
		.geom      (geom),
		.busy      (busy),
		.sync      (sync)
	);

	// Byte intake and classification.
	psu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.geom       (geom),
		.busy       (busy),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry),
		.bir        (bir)
	);

	// Request queue.
	psu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	// Sample emission.
	psu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.sync       (sync),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

`default_nettype wire

@@ hdl/psu_checker.sv @@
// Port-level checks of the packed sample unpacker, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module psu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] sample,
	input wire logic       is_alpha,
	input wire logic       row_end,
	input wire logic       image_end,
	input wire logic       last
);

	logic prev_alpha_q;

	// Remembers whether the last delivered result was an alpha.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_alpha_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			prev_alpha_q <= is_alpha;
		end
	end

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample) && $stable(is_alpha)
			&& $stable(row_end) && $stable(image_end) && $stable(last))
		else $error("result payload changed while stalled");

	// An alpha result never directly follows another alpha.
	a_alpha_after_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && is_alpha |-> !prev_alpha_q)
		else $error("two alpha results in a row");

	// Image end closes a row, and a row end closes the byte's results.
	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (image_end || row_end) |-> row_end && last)
		else $error("end flags inconsistent");

endmodule

bind packed_sample_unpacker psu_checker u_psu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.sample    (out_ch.sample),
	.is_alpha  (out_ch.is_alpha),
	.row_end   (out_ch.row_end),
	.image_end (out_ch.image_end),
	.last      (out_ch.last)
);

`default_nettype wire

@@ test/packed_sample_unpacker_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the packed sample unpacker: drives source byte requests,
// predicts every unpacked sample and compares them field by field.
// Depends on psu_pkg, the channel interfaces in psu_ifs and the packed_sample_unpacker top level.

module packed_sample_unpacker_tb;
	import psu_pkg::*;

	// One expected output request of the unpacker.
	typedef struct packed {
		logic [7:0] sample;
		logic       is_alpha;
		logic       row_end;
		logic       image_end;
		logic       last;
	} sample_rec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [WDATA_W-1:0] cfg_wdata;

	psu_in_if in_ch ();
	psu_out_if out_ch ();

	packed_sample_unpacker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Register copies as the unpacker holds them.
	logic [CODE_W-1:0]   cfg_depth  = CODE_8;
	logic [COMPS_W-1:0]  cfg_comps  = 6'd1;
	logic                cfg_alpha  = 1'b0;
	logic [PIX_W-1:0]    cfg_pixels = 16'd1;
	logic [STRIDE_W-1:0] cfg_stride = 24'd1;
	logic [ROWS_W-1:0]   cfg_rows   = 16'd1;

	// Row position of the predictor.
	logic [STRIDE_W-1:0] byte_pos = '0;
	logic [ROWS_W-1:0]   row_pos  = '0;

	logic [7:0]  pending_bytes[$];
	sample_rec_t expected_samples[$];
	sample_rec_t want;

	int  errors = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  calm = 1'b0;
	bit  hold = 1'b0;

	always #6 clk = ~clk;

	// Splits one accepted source byte into the samples it yields and advances the row position.
	task automatic unpack_byte(input logic [7:0] src);
		logic [CODE_W-1:0] code;
		longint unsigned comps, total, rows, data_bytes, first, count, spb, s, stride, j;
		logic [7:0] alpha_v, val;
		bit last_row, rend, pix_end;
		int unsigned d, sh;
		sample_rec_t rec;
		sample_rec_t batch[$];
		code = (cfg_depth > CODE_16) ? CODE_16 : cfg_depth;
		if (cfg_comps == 0) begin
			comps = 1;
		end else if (cfg_comps > MAX_COMPONENTS) begin
			comps = MAX_COMPONENTS;
		end else begin
			comps = cfg_comps;
		end
		total = longint'(cfg_pixels) * comps;
		rows = (cfg_rows == 0) ? 1 : longint'(cfg_rows);
		last_row = (longint'(row_pos) + 1) >= rows;
		case (code)
			CODE_1: begin
				alpha_v = 8'd1;
			end
			CODE_2: begin
				alpha_v = 8'd3;
			end
			CODE_4: begin
				alpha_v = 8'd15;
			end
			default: begin
				alpha_v = 8'd255;
			end
		endcase

		// A 16-bit sample spans two bytes and only its first byte carries the value.
		if (code == CODE_16) begin
			data_bytes = total * 2;
			first = longint'(byte_pos) >> 1;
			count = byte_pos[0] ? 0 : 1;
		end else begin
			spb = 8 >> code;
			data_bytes = (total + spb - 1) / spb;
			first = longint'(byte_pos) * spb;
			count = spb;
		end

		for (j = 0; j < count; j++) begin
			s = first + j;
			if (s >= total) begin
				break;
			end
			if (code >= CODE_8) begin
				val = src;
			end else begin
				d = 1 << code;
				sh = 8 - d * (int'(j) + 1);
				val = 8'((src >> sh) & ((1 << d) - 1));
			end
			rend = (s + 1) == total;
			pix_end = (s % comps) == comps - 1;
			rec = '0;
			rec.sample = val;
			if (cfg_alpha && pix_end) begin
				batch.push_back(rec);
				rec.sample = alpha_v;
				rec.is_alpha = 1'b1;
			end
			rec.row_end = rend;
			rec.image_end = rend && last_row;
			batch.push_back(rec);
		end

		foreach (batch[k]) begin
			rec = batch[k];
			rec.last = (k == batch.size() - 1);
			expected_samples.push_back(rec);
		end

		// The row lasts at least as long as its samples need, and at least one byte.
		stride = cfg_stride;
		if (stride < data_bytes) begin
			stride = data_bytes;
		end
		if (stride == 0) begin
			stride = 1;
		end
		if (longint'(byte_pos) + 1 >= stride) begin
			byte_pos = '0;
			row_pos = last_row ? '0 : row_pos + 1'b1;
		end else begin
			byte_pos = byte_pos + 1'b1;
		end
	endtask

	// Writes one register and mirrors it into the predictor's copy.
	task automatic set_reg(input reg_idx_t idx, input logic [WDATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_DEPTH_CODE: begin
				cfg_depth = val[CODE_W-1:0];
			end
			REG_COMPONENTS: begin
				cfg_comps = val[COMPS_W-1:0];
			end
			REG_ADD_ALPHA: begin
				cfg_alpha = val[0];
			end
			REG_ROW_PIXELS: begin
				cfg_pixels = val[PIX_W-1:0];
			end
			REG_ROW_STRIDE: begin
				cfg_stride = val[STRIDE_W-1:0];
			end
			REG_ROW_COUNT: begin
				cfg_rows = val[ROWS_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Loads a complete image geometry; only called while the unpacker is idle.
	task automatic apply_config(input logic [CODE_W-1:0] depth, input logic [COMPS_W-1:0] comps,
			input logic alpha, input logic [PIX_W-1:0] pixels, input logic [STRIDE_W-1:0] stride,
			input logic [ROWS_W-1:0] rows);
		set_reg(REG_DEPTH_CODE, WDATA_W'(depth));
		set_reg(REG_COMPONENTS, WDATA_W'(comps));
		set_reg(REG_ADD_ALPHA, WDATA_W'(alpha));
		set_reg(REG_ROW_PIXELS, WDATA_W'(pixels));
		set_reg(REG_ROW_STRIDE, WDATA_W'(stride));
		set_reg(REG_ROW_COUNT, WDATA_W'(rows));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued byte is taken and every sample has come out,
	// optionally holding the sender halfway until the unpacker has fully drained.
	task automatic drain(input bit pause_midway);
		int half;
		half = pending_bytes.size() / 2;
		if (pause_midway) begin
			while (pending_bytes.size() > half) begin
				@(negedge clk);
			end
			hold = 1'b1;
			while (in_ch.valid || expected_samples.size() != 0) begin
				@(negedge clk);
			end
			hold = 1'b0;
		end
		while (pending_bytes.size() != 0 || in_ch.valid || expected_samples.size() != 0) begin
			@(negedge clk);
		end
		// Padding bytes leave no result behind, so give the pipeline time to empty.
		repeat (40) @(posedge clk);
	endtask

	// Source side: presents queued bytes, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.source_byte <= '0;
			send_gap = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (!hold && pending_bytes.size() != 0) begin
				if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 14);
					in_ch.valid <= 1'b0;
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.source_byte <= pending_bytes.pop_front();
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: ready with random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap = 0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
			recv_gap = $urandom_range(0, 14);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted byte and checks each accepted sample request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected result: sample %0d", out_ch.sample);
					errors++;
				end else begin
					want = expected_samples.pop_front();
					if (out_ch.sample !== want.sample) begin
						$error("sample: expected %0d, actual %0d", want.sample, out_ch.sample);
						errors++;
					end
					if (out_ch.is_alpha !== want.is_alpha) begin
						$error("is_alpha: expected %0d, actual %0d", want.is_alpha,
							out_ch.is_alpha);
						errors++;
					end
					if (out_ch.row_end !== want.row_end) begin
						$error("row_end: expected %0d, actual %0d", want.row_end,
							out_ch.row_end);
						errors++;
					end
					if (out_ch.image_end !== want.image_end) begin
						$error("image_end: expected %0d, actual %0d", want.image_end,
							out_ch.image_end);
						errors++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, out_ch.last);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				unpack_byte(in_ch.source_byte);
			end
		end
	end

	// Stimulus: a directed part, then random image geometries with random bytes.
	initial begin
		logic [CODE_W-1:0]   r_depth;
		logic [COMPS_W-1:0]  r_comps;
		logic [PIX_W-1:0]    r_pixels;
		logic [STRIDE_W-1:0] r_stride;
		logic [ROWS_W-1:0]   r_rows;
		logic [7:0]          b;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.source_byte = '0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 20;
		recv_idle_pct = 20;

		// Default geometry: one 8-bit sample per one-row image.
		@(negedge clk);
		pending_bytes = '{8'h00, 8'hFF, 8'hA5};
		drain(1'b0);

		// One-bit samples with alpha: sixteen results per byte.
		apply_config(CODE_1, 6'd1, 1'b1, 16'd8, 24'd1, 16'd1);
		@(negedge clk);
		pending_bytes = '{8'hFF, 8'h00};
		drain(1'b0);

		// Nine-bit rows with skipped tail bits and one padding byte, two rows.
		apply_config(CODE_1, 6'd3, 1'b1, 16'd3, 24'd3, 16'd2);
		@(negedge clk);
		pending_bytes = '{8'hFF, 8'h80, 8'h00, 8'h00, 8'h7F, 8'h55};
		drain(1'b0);

		// Sixteen-bit samples keep the high byte; a stride of zero is too small.
		apply_config(CODE_16, 6'd2, 1'b1, 16'd1, 24'd0, 16'd1);
		@(negedge clk);
		pending_bytes = '{8'hFF, 8'h00, 8'h01, 8'h80};
		drain(1'b0);

		// Depth code above sixteen bits, zero components, zero pixels, zero rows.
		apply_config(3'd7, 6'd0, 1'b0, 16'd0, 24'd2, 16'd0);
		@(negedge clk);
		pending_bytes = '{8'hAA, 8'h55};
		drain(1'b0);

		// Two-bit and four-bit samples.
		apply_config(CODE_2, 6'd1, 1'b0, 16'd4, 24'd1, 16'd1);
		@(negedge clk);
		pending_bytes = '{8'hE4};
		drain(1'b0);
		apply_config(CODE_4, 6'd2, 1'b1, 16'd1, 24'd1, 16'd1);
		@(negedge clk);
		pending_bytes = '{8'hC3};
		drain(1'b0);

		// A row shortened mid-way ends on the next byte.
		apply_config(CODE_8, 6'd1, 1'b0, 16'd4, 24'd4, 16'd1);
		@(negedge clk);
		pending_bytes = '{8'h11, 8'h22, 8'h33};
		drain(1'b0);
		apply_config(CODE_8, 6'd1, 1'b0, 16'd2, 24'd2, 16'd1);
		@(negedge clk);
		pending_bytes = '{8'h44, 8'h55};
		drain(1'b0);

		// Random geometries; one phase uses the largest effective geometry values.
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin
				r_depth = CODE_16;
				r_comps = 6'd32;
				r_pixels = 16'hFFFF;
				r_stride = 24'hFFFFFF;
				r_rows = 16'hFFFF;
			end else begin
				r_depth = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				case ($urandom_range(0, 7))
					0: begin
						r_comps = 6'd0;
					end
					1: begin
						r_comps = 6'($urandom_range(32, 63));
					end
					default: begin
						r_comps = 6'($urandom_range(1, 4));
					end
				endcase
				r_pixels = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
				if (r_comps > 6'd4) begin
					r_pixels = 16'd1;
				end
				r_stride = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 12));
				r_rows = 16'($urandom_range(0, 3));
			end
			apply_config(r_depth, r_comps, 1'($urandom_range(0, 1)), r_pixels, r_stride, r_rows);

			@(negedge clk);
			case ($urandom_range(0, 2))
				0: begin
					send_idle_pct = 0;
				end
				1: begin
					send_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 30;
				end
			endcase
			case ($urandom_range(0, 2))
				0: begin
					recv_idle_pct = 0;
				end
				1: begin
					recv_idle_pct = 10;
				end
				default: begin
					recv_idle_pct = 30;
				end
			endcase
			calm = (phase >= 10);
			for (int k = 0; k < 21; k++) begin
				if ($urandom_range(0, 9) < 3) begin
					case ($urandom_range(0, 5))
						0: b = 8'h00;
						1: b = 8'hFF;
						2: b = 8'h80;
						3: b = 8'h01;
						4: b = 8'h7F;
						default: b = 8'hFE;
					endcase
				end else begin
					b = 8'($urandom_range(0, 255));
				end
				pending_bytes.push_back(b);
			end
			drain(phase == 2);
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/psu_pkg.sv
hdl/psu_ifs.sv
hdl/psu_cfg.sv
hdl/psu_front.sv
hdl/psu_queue.sv
hdl/psu_back.sv
hdl/packed_sample_unpacker.sv
hdl/psu_checker.sv
test/packed_sample_unpacker_tb.sv
